@@ src/psd_pkg.sv @@
// Shared widths, result codes and pipeline payload types for the point-to-segment
// squared-distance block. No dependencies.
package psd_pkg;

  localparam int CW  = 24;            // coordinate width
  localparam int DFW = CW + 1;        // coordinate difference width
  localparam int PW  = 2 * DFW;       // product of two differences
  localparam int SW  = PW + 1;        // sum of two products
  localparam int LW  = (SW + 1) / 2;  // low half of |cross| for squaring
  localparam int HW  = SW - LW;       // high half of |cross|
  localparam int NW  = 2 * SW;        // cross squared
  localparam int OW  = 50;            // result width
  localparam int QW  = OW;            // quotient bits produced by the divider
  localparam int DIV_STAGES = QW;     // one quotient bit per stage

  typedef enum logic [1:0] {
    PART_START = 2'd0,
    PART_END   = 2'd1,
    PART_MID   = 2'd2
  } part_e;

  // Sideband that rides along with the divider
  typedef struct packed {
    part_e           part;
    logic [SW-1:0]   dist_end;
  } side_t;

  // Restoring divider working set
  typedef struct packed {
    logic [SW-1:0] rem;
    logic [QW-1:0] low;
    logic [QW-1:0] quo;
    logic [SW-1:0] den;
  } div_t;

endpackage

@@ src/psd_front.sv @@
// Front end: differences, products, dot/cross sums and nearest-part select (3 stages).
// Depends on psd_pkg.
module psd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [psd_pkg::CW-1:0]      ax_i,
  input  logic [psd_pkg::CW-1:0]      ay_i,
  input  logic [psd_pkg::CW-1:0]      bx_i,
  input  logic [psd_pkg::CW-1:0]      by_i,
  input  logic [psd_pkg::CW-1:0]      px_i,
  input  logic [psd_pkg::CW-1:0]      py_i,
  output logic                        valid_o,
  output psd_pkg::side_t              side_o,
  output logic [psd_pkg::SW-1:0]      cm_o,
  output logic [psd_pkg::SW-1:0]      den_o
);
  import psd_pkg::*;

  logic                  v1_q, v2_q, v3_q;
  logic signed [DFW-1:0] nx_q, ny_q, pax_q, pay_q, bpx_q, bpy_q;
  logic signed [PW-1:0]  c1_q, c2_q, d1_q, d2_q, x1_q, x2_q;
  logic signed [PW-1:0]  a1_q, a2_q, b1_q, b2_q, n1_q, n2_q;
  logic                  nz_q;
  logic signed [SW-1:0]  c_d, d_d, cross_d;
  logic [SW-1:0]         da_d, db_d, nn_d, cm_d;
  side_t                 side_d, side_q;
  logic [SW-1:0]         cm_q, den_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 1: sign-extended differences
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q  <= $signed({bx_i[CW-1], bx_i}) - $signed({ax_i[CW-1], ax_i});
      ny_q  <= $signed({by_i[CW-1], by_i}) - $signed({ay_i[CW-1], ay_i});
      pax_q <= $signed({ax_i[CW-1], ax_i}) - $signed({px_i[CW-1], px_i});
      pay_q <= $signed({ay_i[CW-1], ay_i}) - $signed({py_i[CW-1], py_i});
      bpx_q <= $signed({px_i[CW-1], px_i}) - $signed({bx_i[CW-1], bx_i});
      bpy_q <= $signed({py_i[CW-1], py_i}) - $signed({by_i[CW-1], by_i});
    end
  end

  // Stage 2: one row of independent multipliers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q <= nx_q * pax_q;
      c2_q <= ny_q * pay_q;
      d1_q <= nx_q * bpx_q;
      d2_q <= ny_q * bpy_q;
      x1_q <= nx_q * pay_q;
      x2_q <= ny_q * pax_q;
      a1_q <= pax_q * pax_q;
      a2_q <= pay_q * pay_q;
      b1_q <= bpx_q * bpx_q;
      b2_q <= bpy_q * bpy_q;
      n1_q <= nx_q * nx_q;
      n2_q <= ny_q * ny_q;
      nz_q <= (nx_q == '0) && (ny_q == '0);
    end
  end

  // Stage 3: sums and nearest-part decision
  always_comb begin
    c_d     = $signed({c1_q[PW-1], c1_q}) + $signed({c2_q[PW-1], c2_q});
    d_d     = $signed({d1_q[PW-1], d1_q}) + $signed({d2_q[PW-1], d2_q});
    cross_d = $signed({x1_q[PW-1], x1_q}) - $signed({x2_q[PW-1], x2_q});
    da_d    = {1'b0, a1_q} + {1'b0, a2_q};
    db_d    = {1'b0, b1_q} + {1'b0, b2_q};
    nn_d    = {1'b0, n1_q} + {1'b0, n2_q};
    cm_d    = cross_d[SW-1] ? SW'(-cross_d) : SW'(cross_d);
    if ((!c_d[SW-1] && (c_d != '0)) || nz_q) begin
      side_d.part     = PART_START;
      side_d.dist_end = da_d;
    end else if (!d_d[SW-1] && (d_d != '0)) begin
      side_d.part     = PART_END;
      side_d.dist_end = db_d;
    end else begin
      side_d.part     = PART_MID;
      side_d.dist_end = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      cm_q   <= cm_d;
      den_q  <= nn_d;
    end
  end

  assign valid_o = v3_q;
  assign side_o  = side_q;
  assign cm_o    = cm_q;
  assign den_o   = den_q;

endmodule

@@ src/psd_square.sv @@
// Squares |cross| through split partial products (2 stages) and loads the divider.
// Depends on psd_pkg.
module psd_square (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  psd_pkg::side_t         side_i,
  input  logic [psd_pkg::SW-1:0] cm_i,
  input  logic [psd_pkg::SW-1:0] den_i,
  output logic                   valid_o,
  output psd_pkg::side_t         side_o,
  output psd_pkg::div_t          div_o
);
  import psd_pkg::*;

  logic               v4_q, v5_q;
  logic [2*HW-1:0]    hh_q;
  logic [HW+LW-1:0]   hl_q;
  logic [2*LW-1:0]    ll_q;
  side_t              side4_q, side5_q;
  logic [SW-1:0]      den4_q;
  logic [NW-1:0]      sq_d;
  div_t               div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= valid_i;
      v5_q <= v4_q;
    end
  end

  // Stage 4: partial products of the split magnitude
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q    <= (2*HW)'(cm_i[SW-1:LW]) * (2*HW)'(cm_i[SW-1:LW]);
      hl_q    <= (HW+LW)'(cm_i[SW-1:LW]) * (HW+LW)'(cm_i[LW-1:0]);
      ll_q    <= (2*LW)'(cm_i[LW-1:0]) * (2*LW)'(cm_i[LW-1:0]);
      side4_q <= side_i;
      den4_q  <= den_i;
    end
  end

  // Stage 5: combine partial products and seed the divider
  assign sq_d = (NW'(hh_q) << (2*LW)) + (NW'(hl_q) << (LW+1)) + NW'(ll_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q.rem <= sq_d[QW +: SW];
      div_q.low <= sq_d[QW-1:0];
      div_q.quo <= '0;
      div_q.den <= den4_q;
      side5_q   <= side4_q;
    end
  end

  assign valid_o = v5_q;
  assign side_o  = side5_q;
  assign div_o   = div_q;

endmodule

@@ src/psd_div_stage.sv @@
// One registered step of the restoring divider: one quotient bit per stage.
// Depends on psd_pkg.
module psd_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  psd_pkg::side_t side_i,
  input  psd_pkg::div_t  div_i,
  output logic           valid_o,
  output psd_pkg::side_t side_o,
  output psd_pkg::div_t  div_o
);
  import psd_pkg::*;

  logic [SW:0] rs_d;
  logic        ge_d;
  div_t        div_d, div_q;
  side_t       side_q;
  logic        v_q;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    rs_d      = {div_i.rem, div_i.low[QW-1]};
    ge_d      = rs_d >= {1'b0, div_i.den};
    div_d.rem = ge_d ? SW'(rs_d - {1'b0, div_i.den}) : rs_d[SW-1:0];
    div_d.low = div_i.low << 1;
    div_d.quo = {div_i.quo[QW-2:0], ge_d};
    div_d.den = div_i.den;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q  <= div_d;
      side_q <= side_i;
    end
  end

  assign valid_o = v_q;
  assign side_o  = side_q;
  assign div_o   = div_q;

endmodule

@@ src/point_segment_squared_distance_top.sv @@
// Squared distance from a point to a segment, fully pipelined: one item per cycle
// unless the output stalls, in 3 front, 2 squaring, 50 divider and 1 output stages.
// The divider chain, one quotient bit per stage, sets the depth. A stalled output holds
// the whole pipeline. Depends on psd_pkg, psd_front, psd_square, psd_div_stage.
module point_segment_squared_distance_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [psd_pkg::CW-1:0] seg_start_x_i,
  input  logic [psd_pkg::CW-1:0] seg_start_y_i,
  input  logic [psd_pkg::CW-1:0] seg_end_x_i,
  input  logic [psd_pkg::CW-1:0] seg_end_y_i,
  input  logic [psd_pkg::CW-1:0] point_x_i,
  input  logic [psd_pkg::CW-1:0] point_y_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [psd_pkg::OW-1:0] squared_distance_o,
  output logic [1:0]             nearest_part_o
);
  import psd_pkg::*;

  logic          en;
  logic          fr_valid, sq_valid;
  side_t         fr_side;
  logic [SW-1:0] fr_cm, fr_den;
  logic          dv_valid [DIV_STAGES+1];
  side_t         dv_side  [DIV_STAGES+1];
  div_t          dv_div   [DIV_STAGES+1];
  logic          out_valid_q;
  logic [OW-1:0] dist_q;
  part_e         part_q;

  // Hold every stage while the output item waits
  assign en         = out_ready_i || !out_valid_q;
  assign in_ready_o = en;

  psd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .ax_i    (seg_start_x_i),
    .ay_i    (seg_start_y_i),
    .bx_i    (seg_end_x_i),
    .by_i    (seg_end_y_i),
    .px_i    (point_x_i),
    .py_i    (point_y_i),
    .valid_o (fr_valid),
    .side_o  (fr_side),
    .cm_o    (fr_cm),
    .den_o   (fr_den)
  );

  psd_square u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .side_i  (fr_side),
    .cm_i    (fr_cm),
    .den_i   (fr_den),
    .valid_o (sq_valid),
    .side_o  (dv_side[0]),
    .div_o   (dv_div[0])
  );
  assign dv_valid[0] = sq_valid;

  // Divider chain
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    psd_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_valid[g]),
      .side_i  (dv_side[g]),
      .div_i   (dv_div[g]),
      .valid_o (dv_valid[g+1]),
      .side_o  (dv_side[g+1]),
      .div_o   (dv_div[g+1])
    );
  end

  // Output register: pick endpoint distance or interior quotient
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      part_q <= dv_side[DIV_STAGES].part;
      dist_q <= (dv_side[DIV_STAGES].part == PART_MID) ? dv_div[DIV_STAGES].quo
                                                       : dv_side[DIV_STAGES].dist_end[OW-1:0];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign squared_distance_o = dist_q;
  assign nearest_part_o     = part_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("pipeline stalled without a waiting item");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(squared_distance_o))
    else $error("waiting result changed");
  a_mid_nonzero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_valid && (dv_side[0].part == PART_MID) |-> (dv_div[0].den != '0))
    else $error("interior case with zero-length segment");
`endif

endmodule

@@ sim/point_segment_squared_distance_top_tb.sv @@
// Testbench for point_segment_squared_distance_top: directed and random segment/point items,
// checked against an in-bench squared-distance predictor. Depends on psd_pkg and the block RTL.
module point_segment_squared_distance_top_tb;
  import psd_pkg::*;

  typedef struct {
    logic [CW-1:0] ax, ay, bx, by, px, py;
  } seg_query_t;

  typedef struct {
    logic [OW-1:0] sq_dist;
    part_e         part;
  } dist_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [CW-1:0] seg_start_x_i = '0, seg_start_y_i = '0, seg_end_x_i = '0;
  logic [CW-1:0] seg_end_y_i = '0, point_x_i = '0, point_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [OW-1:0] squared_distance_o;
  logic [1:0] nearest_part_o;

  seg_query_t   pending_q[$];
  dist_result_t expected_q[$];
  int  errors = 0;
  int  send_idle_pct = 16, recv_idle_pct = 72;
  int  hold_cycles = 0;
  bit  pause_sender = 1'b0;
  bit  stim_done = 1'b0;
  bit  took_item = 1'b0;

  point_segment_squared_distance_top DUT (.*);

  // Clock, period 2
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predict distance and nearest part for one item
  function automatic dist_result_t predict_distance(seg_query_t q);
    longint signed ax, ay, bx, by, px, py, nx, ny, pax, pay, bpx, bpy, c, d, cr;
    logic [127:0] num, nn;
    dist_result_t r;
    ax = longint'($signed(q.ax)); ay = longint'($signed(q.ay));
    bx = longint'($signed(q.bx)); by = longint'($signed(q.by));
    px = longint'($signed(q.px)); py = longint'($signed(q.py));
    nx = bx - ax; ny = by - ay;
    pax = ax - px; pay = ay - py;
    bpx = px - bx; bpy = py - by;
    c = nx * pax + ny * pay;
    d = nx * bpx + ny * bpy;
    if (c > 0 || (nx == 0 && ny == 0)) begin
      r.sq_dist = OW'(pax * pax + pay * pay);
      r.part = PART_START;
    end else if (d > 0) begin
      r.sq_dist = OW'(bpx * bpx + bpy * bpy);
      r.part = PART_END;
    end else begin
      cr = nx * pay - ny * pax;
      if (cr < 0) cr = -cr;
      num = 128'(cr) * 128'(cr);
      nn = 128'(nx * nx + ny * ny);
      r.sq_dist = OW'(num / nn);
      r.part = PART_MID;
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(CW-1){1'b0}}};
      1: return {1'b0, {(CW-1){1'b1}}};
      2: return CW'($urandom_range(0, 15)) - CW'(8);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic seg_query_t rand_query();
    seg_query_t q;
    q.ax = rand_coord(); q.ay = rand_coord();
    q.bx = rand_coord(); q.by = rand_coord();
    q.px = rand_coord(); q.py = rand_coord();
    case ($urandom_range(0, 5))
      // zero-length segment
      0: begin q.bx = q.ax; q.by = q.ay; end
      // small local geometry to get ties and interior hits
      1: begin
        q.ax = CW'($urandom_range(0, 40)) - CW'(20); q.ay = CW'($urandom_range(0, 40)) - CW'(20);
        q.bx = CW'($urandom_range(0, 40)) - CW'(20); q.by = CW'($urandom_range(0, 40)) - CW'(20);
        q.px = CW'($urandom_range(0, 40)) - CW'(20); q.py = CW'($urandom_range(0, 40)) - CW'(20);
      end
      default: ;
    endcase
    return q;
  endfunction

  function automatic seg_query_t mk(int ax, int ay, int bx, int by, int px, int py);
    seg_query_t q;
    q.ax = CW'(ax); q.ay = CW'(ay); q.bx = CW'(bx);
    q.by = CW'(by); q.px = CW'(px); q.py = CW'(py);
    return q;
  endfunction

  // Driver: offer items from the pending queue at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || took_item) begin
        if (pending_q.size() > 0 && !pause_sender &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          seg_start_x_i <= pending_q[0].ax; seg_start_y_i <= pending_q[0].ay;
          seg_end_x_i <= pending_q[0].bx;   seg_end_y_i <= pending_q[0].by;
          point_x_i <= pending_q[0].px;     point_y_i <= pending_q[0].py;
          expected_q.push_back(predict_distance(pending_q[0]));
          void'(pending_q.pop_front());
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: hold off for a long stretch when asked, else random stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Record input handshakes at the rising edge
  always @(posedge clk_i) begin
    took_item <= in_valid_i && in_ready_o;
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: squared_distance=%0d nearest_part=%0d",
               squared_distance_o, nearest_part_o);
        errors++;
      end else begin
        if (squared_distance_o !== expected_q[0].sq_dist) begin
          $error("squared_distance: expected %0d, actual %0d",
                 expected_q[0].sq_dist, squared_distance_o);
          errors++;
        end
        if (nearest_part_o !== expected_q[0].part) begin
          $error("nearest_part: expected %0d, actual %0d",
                 expected_q[0].part, nearest_part_o);
          errors++;
        end
        void'(expected_q.pop_front());
      end
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0)
      @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // Directed: extremes, zero-length, ties, each nearest part
    pending_q.push_back(mk(0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(5, 5, 5, 5, -3, 9));
    pending_q.push_back(mk(0, 0, 10, 0, -4, 3));
    pending_q.push_back(mk(0, 0, 10, 0, 14, -3));
    pending_q.push_back(mk(0, 0, 10, 0, 4, 3));
    pending_q.push_back(mk(0, 0, 10, 0, 0, 7));
    pending_q.push_back(mk(0, 0, 10, 0, 10, 7));
    pending_q.push_back(mk(0, 0, 3, 7, 2, 1));
    pending_q.push_back(mk(-8388608, -8388608, 8388607, 8388607, 8388607, -8388608));
    pending_q.push_back(mk(-8388608, -8388608, -8388608, -8388608, 8388607, 8388607));
    pending_q.push_back(mk(-8388608, 8388607, 8388607, -8388608, -8388608, -8388608));
    pending_q.push_back(mk(8388607, 8388607, -8388608, -8388608, -8388608, 8388607));
    pending_q.push_back(mk(-8388608, 0, 8388607, 0, 0, 8388607));
    pending_q.push_back(mk(-8388608, -8388608, 8388607, 8388607, 8388607, 8388607));
    pending_q.push_back(mk(-1, -1, -1, -1, -1, -1));
    pending_q.push_back(mk(1, 2, 1, 2, 8388607, -8388608));
    // Long receiver hold while the sender keeps offering
    hold_cycles = 200;
    for (int i = 0; i < 150; i++) pending_q.push_back(rand_query());
    wait_drained();
    // Sender pause after everything is back
    pause_sender = 1'b1;
    repeat (20) @(posedge clk_i);
    pause_sender = 1'b0;
    for (int i = 0; i < 500; i++) pending_q.push_back(rand_query());
    wait_drained();
    send_idle_pct = 72; recv_idle_pct = 16;
    for (int i = 0; i < 500; i++) pending_q.push_back(rand_query());
    wait_drained();
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < 550; i++) pending_q.push_back(rand_query());
    wait_drained();
    repeat (60) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
